>>> rtl/ehd_pkg.sv
package ehd_pkg;

	localparam int unsigned NUM_STAGES = 10;

	localparam int unsigned YEAR_W = 14;
	localparam int unsigned DOY_W  = 9;

	// reciprocals for constant division, quotient = (x * RECIP) >> SH
	localparam logic [12:0] RECIP_100    = 13'd5243;
	localparam int unsigned RECIP_100_SH = 19;
	localparam logic [15:0] RECIP_19     = 16'd55189;
	localparam int unsigned RECIP_19_SH  = 20;
	localparam logic [7:0]  RECIP_3      = 8'd171;
	localparam int unsigned RECIP_3_SH   = 9;
	localparam logic [9:0]  RECIP_30     = 10'd547;
	localparam int unsigned RECIP_30_SH  = 14;
	localparam logic [7:0]  RECIP_7      = 8'd147;
	localparam int unsigned RECIP_7_SH   = 10;

	localparam logic [DOY_W-1:0] CARNIVAL_OFS    = 9'd49;
	localparam logic [DOY_W-1:0] GOOD_FRIDAY_OFS = 9'd2;
	localparam logic [DOY_W-1:0] ASCENSION_OFS   = 9'd39;
	localparam logic [DOY_W-1:0] WHITSUN_OFS     = 9'd49;

	localparam logic [DOY_W-1:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} ehd_ctl_t;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
	} ehd_date_t;

	typedef struct packed {
		logic [4:0] pascha_day;
		logic [2:0] pascha_month;
		logic [4:0] carnival_day;
		logic [1:0] carnival_month;
		logic [4:0] good_friday_day;
		logic [2:0] good_friday_month;
		logic [4:0] ascension_day;
		logic [2:0] ascension_month;
		logic [4:0] whitsun_day;
		logic [2:0] whitsun_month;
		logic       leap_year;
	} ehd_result_t;

	// day of year -> day and month; month starts are compared in parallel
	function automatic ehd_date_t split_doy(input logic [DOY_W-1:0] doy, input logic leap);
		logic [3:0]       mon;
		logic [DOY_W-1:0] start;
		logic [DOY_W-1:0] bound;
		ehd_date_t        r;
		mon   = 4'd1;
		start = '0;
		for (int mm = 2; mm <= 12; mm++) begin
			bound = MONTH_START[mm-1] + ((mm > 2) ? DOY_W'(leap) : DOY_W'(0));
			if (doy > bound) begin
				mon   = 4'(mm);
				start = bound;
			end
		end
		r.month = mon;
		r.day   = (doy > start) ? 5'(doy - start) : 5'd1;
		return r;
	endfunction

endpackage

>>> rtl/ehd_year_if.sv
interface ehd_year_if;
	logic        valid;
	logic        ready;
	logic [13:0] year;

	modport source (output valid, output year, input ready);
	modport sink (input valid, input year, output ready);
endinterface

>>> rtl/ehd_date_if.sv
interface ehd_date_if;
	logic       valid;
	logic       ready;
	logic [4:0] pascha_day;
	logic [2:0] pascha_month;
	logic [4:0] carnival_day;
	logic [1:0] carnival_month;
	logic [4:0] good_friday_day;
	logic [2:0] good_friday_month;
	logic [4:0] ascension_day;
	logic [2:0] ascension_month;
	logic [4:0] whitsun_day;
	logic [2:0] whitsun_month;
	logic       leap_year;

	modport source (
		output valid, input ready,
		output pascha_day, output pascha_month, output carnival_day, output carnival_month,
		output good_friday_day, output good_friday_month, output ascension_day,
		output ascension_month, output whitsun_day, output whitsun_month, output leap_year
	);
	modport sink (
		input valid, output ready,
		input pascha_day, input pascha_month, input carnival_day, input carnival_month,
		input good_friday_day, input good_friday_month, input ascension_day,
		input ascension_month, input whitsun_day, input whitsun_month, input leap_year
	);
endinterface

>>> rtl/easter_holy_days_calculator_top.sv
// Easter and holy days calculator. Each beat on years carries a Gregorian year; the matching
// beat on dates gives Easter Sunday (anonymous Gregorian computus), Carnival (-49 days),
// Good Friday (-2), Ascension (+39), Whitsun (+49) as day and month, plus the leap-year flag.
// The datapath is a ten-stage pipeline: one year is accepted every cycle unless a stalled
// output has backed up to the first stage. Each stage holds a valid bit and refills as soon
// as its successor moves, so a stalled output only backs up as far as needed and bubbles are
// squeezed out. No configuration, no state beyond the pipeline; results keep input order.
module easter_holy_days_calculator_top (
	input  logic       clk,
	input  logic       arst_n,
	ehd_year_if.sink   years,
	ehd_date_if.source dates
);
	import ehd_pkg::*;

	ehd_ctl_t    ctl;
	logic [7:0]  base;
	logic        leap;
	ehd_result_t res;

	ehd_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (years.valid),
		.in_ready  (years.ready),
		.out_valid (dates.valid),
		.out_ready (dates.ready),
		.ctl       (ctl)
	);

	ehd_computus u_computus (
		.clk     (clk),
		.ctl     (ctl),
		.year    (years.year),
		.base_s8 (base),
		.leap_s8 (leap)
	);

	ehd_dates u_dates (
		.clk     (clk),
		.ctl     (ctl),
		.base    (base),
		.leap    (leap),
		.res_s10 (res)
	);

	assign dates.pascha_day        = res.pascha_day;
	assign dates.pascha_month      = res.pascha_month;
	assign dates.carnival_day      = res.carnival_day;
	assign dates.carnival_month    = res.carnival_month;
	assign dates.good_friday_day   = res.good_friday_day;
	assign dates.good_friday_month = res.good_friday_month;
	assign dates.ascension_day     = res.ascension_day;
	assign dates.ascension_month   = res.ascension_month;
	assign dates.whitsun_day       = res.whitsun_day;
	assign dates.whitsun_month     = res.whitsun_month;
	assign dates.leap_year         = res.leap_year;

endmodule

>>> rtl/ehd_pipe_ctl.sv
module ehd_pipe_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ehd_pkg::ehd_ctl_t ctl
);
	import ehd_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	// a stage loads when empty or when the stage after it moves
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_STAGES-1];
	assign ctl.en    = en;

endmodule

>>> rtl/ehd_computus.sv
module ehd_computus (
	input  logic                        clk,
	input  ehd_pkg::ehd_ctl_t           ctl,
	input  logic [ehd_pkg::YEAR_W-1:0]  year,
	output logic [7:0]                  base_s8,
	output logic                        leap_s8
);
	import ehd_pkg::*;

	// stage 1: reciprocal products for /100 and /19
	logic [26:0]       prod_b;
	logic [29:0]       prod_19;
	logic [YEAR_W-1:0] y_s1;
	logic [7:0]        qb_s1;
	logic [9:0]        q19_s1;

	assign prod_b  = 27'(year) * 27'(RECIP_100);
	assign prod_19 = 30'(year) * 30'(RECIP_19);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			y_s1   <= year;
			qb_s1  <= 8'(prod_b >> RECIP_100_SH);
			q19_s1 <= 10'(prod_19 >> RECIP_19_SH);
		end
	end

	// stage 2: remainders, f, leap
	logic [YEAR_W-1:0] c_full;
	logic [YEAR_W-1:0] a_full;
	logic [2:0]        f_c;
	logic [4:0]        a_s2;
	logic [7:0]        b_s2;
	logic [6:0]        c_s2;
	logic [2:0]        f_s2;
	logic              leap_s2;

	assign c_full = y_s1 - 14'(14'(qb_s1) * 14'd100);
	assign a_full = y_s1 - 14'(14'(q19_s1) * 14'd19);
	assign f_c    = 3'(qb_s1 >= 8'd17) + 3'(qb_s1 >= 8'd42) + 3'(qb_s1 >= 8'd67)
	              + 3'(qb_s1 >= 8'd92) + 3'(qb_s1 >= 8'd117) + 3'(qb_s1 >= 8'd142);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			a_s2    <= 5'(a_full);
			b_s2    <= qb_s1;
			c_s2    <= 7'(c_full);
			f_s2    <= f_c;
			leap_s2 <= (y_s1[1:0] == 2'd0) && ((c_full != '0) || (qb_s1[1:0] == 2'd0));
		end
	end

	// stage 3: g and the first part of h
	logic [8:0]  gx;
	logic [16:0] prod_g;
	logic [9:0]  hp;
	logic [6:0]  g_s3;
	logic [9:0]  hp_s3;
	logic [4:0]  a_s3;
	logic [4:0]  i_s3;
	logic [1:0]  k_s3;
	logic [1:0]  e_s3;
	logic        leap_s3;

	assign gx     = 9'(b_s2) - 9'(f_s2) + 9'd1;
	assign prod_g = 17'(gx) * 17'(RECIP_3);
	assign hp     = 10'(a_s2) * 10'd19 + 10'(b_s2) - 10'(b_s2[7:2]) + 10'd15;

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			g_s3    <= 7'(prod_g >> RECIP_3_SH);
			hp_s3   <= hp;
			a_s3    <= a_s2;
			i_s3    <= c_s2[6:2];
			k_s3    <= c_s2[1:0];
			e_s3    <= b_s2[1:0];
			leap_s3 <= leap_s2;
		end
	end

	// stage 4: h before mod 30, quotient by 30
	logic [9:0]  hx;
	logic [19:0] prod_h;
	logic [9:0]  hx_s4;
	logic [5:0]  hq_s4;
	logic [4:0]  a_s4;
	logic [4:0]  i_s4;
	logic [1:0]  k_s4;
	logic [1:0]  e_s4;
	logic        leap_s4;

	assign hx     = hp_s3 - 10'(g_s3);
	assign prod_h = 20'(hx) * 20'(RECIP_30);

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			hx_s4   <= hx;
			hq_s4   <= 6'(prod_h >> RECIP_30_SH);
			a_s4    <= a_s3;
			i_s4    <= i_s3;
			k_s4    <= k_s3;
			e_s4    <= e_s3;
			leap_s4 <= leap_s3;
		end
	end

	// stage 5: h
	logic [4:0] h_s5;
	logic [4:0] a_s5;
	logic [4:0] i_s5;
	logic [1:0] k_s5;
	logic [1:0] e_s5;
	logic       leap_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			h_s5    <= 5'(hx_s4 - 10'(hq_s4) * 10'd30);
			a_s5    <= a_s4;
			i_s5    <= i_s4;
			k_s5    <= k_s4;
			e_s5    <= e_s4;
			leap_s5 <= leap_s4;
		end
	end

	// stage 6: l before mod 7, quotient by 7
	logic [7:0]  lx;
	logic [15:0] prod_l;
	logic [6:0]  lx_s6;
	logic [3:0]  lq_s6;
	logic [4:0]  h_s6;
	logic [4:0]  a_s6;
	logic        leap_s6;

	assign lx     = 8'd32 + 8'({e_s5, 1'b0}) + 8'({i_s5, 1'b0}) - 8'(h_s5) - 8'(k_s5);
	assign prod_l = 16'(lx) * 16'(RECIP_7);

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			lx_s6   <= 7'(lx);
			lq_s6   <= 4'(prod_l >> RECIP_7_SH);
			h_s6    <= h_s5;
			a_s6    <= a_s5;
			leap_s6 <= leap_s5;
		end
	end

	// stage 7: l
	logic [2:0] l_s7;
	logic [4:0] h_s7;
	logic [4:0] a_s7;
	logic       leap_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			l_s7    <= 3'(lx_s6 - 7'(lq_s6) * 7'd7);
			h_s7    <= h_s6;
			a_s7    <= a_s6;
			leap_s7 <= leap_s6;
		end
	end

	// stage 8: m correction and the date base
	logic [8:0] mx;
	logic       m_c;

	assign mx  = 9'(a_s7) + 9'(h_s7) * 9'd11 + 9'(l_s7) * 9'd22;
	assign m_c = (mx >= 9'd451);

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			base_s8 <= 8'(h_s7) + 8'(l_s7) + 8'd114 - (m_c ? 8'd7 : 8'd0);
			leap_s8 <= leap_s7;
		end
	end

endmodule

>>> rtl/ehd_dates.sv
module ehd_dates (
	input  logic                 clk,
	input  ehd_pkg::ehd_ctl_t    ctl,
	input  logic [7:0]           base,
	input  logic                 leap,
	output ehd_pkg::ehd_result_t res_s10
);
	import ehd_pkg::*;

	// stage 9: Easter day, month and day of year
	logic             april;
	logic [4:0]       eday_s9;
	logic [2:0]       emon_s9;
	logic [DOY_W-1:0] doy_s9;
	logic             leap_s9;

	assign april = (base >= 8'd124);

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			eday_s9 <= april ? 5'(base - 8'd123) : 5'(base - 8'd92);
			emon_s9 <= april ? 3'd4 : 3'd3;
			doy_s9  <= 9'(base) - 9'd33 + 9'(leap);
			leap_s9 <= leap;
		end
	end

	// stage 10: holy days back to day and month
	ehd_date_t carn;
	ehd_date_t gfri;
	ehd_date_t ascn;
	ehd_date_t whit;

	assign carn = split_doy((doy_s9 > CARNIVAL_OFS) ? doy_s9 - CARNIVAL_OFS : 9'd1, leap_s9);
	assign gfri = split_doy((doy_s9 > GOOD_FRIDAY_OFS) ? doy_s9 - GOOD_FRIDAY_OFS : 9'd1,
		leap_s9);
	assign ascn = split_doy(doy_s9 + ASCENSION_OFS, leap_s9);
	assign whit = split_doy(doy_s9 + WHITSUN_OFS, leap_s9);

	always_ff @(posedge clk) begin
		if (ctl.en[9]) begin
			res_s10.pascha_day        <= eday_s9;
			res_s10.pascha_month      <= emon_s9;
			res_s10.carnival_day      <= carn.day;
			res_s10.carnival_month    <= carn.month[1:0];
			res_s10.good_friday_day   <= gfri.day;
			res_s10.good_friday_month <= gfri.month[2:0];
			res_s10.ascension_day     <= ascn.day;
			res_s10.ascension_month   <= ascn.month[2:0];
			res_s10.whitsun_day       <= whit.day;
			res_s10.whitsun_month     <= whit.month[2:0];
			res_s10.leap_year         <= leap_s9;
		end
	end

endmodule

>>> rtl/ehd_checker.sv
module ehd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] pascha_day,
	input logic [2:0] pascha_month,
	input logic [4:0] carnival_day,
	input logic [1:0] carnival_month,
	input logic [4:0] good_friday_day,
	input logic [2:0] good_friday_month,
	input logic [4:0] ascension_day,
	input logic [2:0] ascension_month,
	input logic [4:0] whitsun_day,
	input logic [2:0] whitsun_month,
	input logic       leap_year
);

	// stalled beat holds; checked on Easter day and month, Carnival day, Whitsun day and leap flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pascha_day) && $stable(pascha_month)
			&& $stable(carnival_day) && $stable(whitsun_day) && $stable(leap_year))
		else $error("stalled result changed");

	a_months: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pascha_month == 3'd3 || pascha_month == 3'd4)
			&& (carnival_month == 2'd2 || carnival_month == 2'd3)
			&& (whitsun_month == 3'd5 || whitsun_month == 3'd6))
		else $error("month out of range");

	a_good_friday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pascha_day > 5'd2 |-> good_friday_day == pascha_day - 5'd2
			&& good_friday_month == pascha_month)
		else $error("good friday not two days before easter");

	a_ascension: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && whitsun_day > 5'd10 |-> ascension_day == whitsun_day - 5'd10
			&& ascension_month == whitsun_month)
		else $error("ascension not ten days before whitsun");

endmodule

bind easter_holy_days_calculator_top ehd_checker u_ehd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (dates.valid),
	.out_ready         (dates.ready),
	.pascha_day        (dates.pascha_day),
	.pascha_month      (dates.pascha_month),
	.carnival_day      (dates.carnival_day),
	.carnival_month    (dates.carnival_month),
	.good_friday_day   (dates.good_friday_day),
	.good_friday_month (dates.good_friday_month),
	.ascension_day     (dates.ascension_day),
	.ascension_month   (dates.ascension_month),
	.whitsun_day       (dates.whitsun_day),
	.whitsun_month     (dates.whitsun_month),
	.leap_year         (dates.leap_year)
);
